>>> src/hmmb_pkg.sv
`default_nettype none

package hmmb_pkg;

  typedef enum logic [2:0] {
    OP_RD_BYTE  = 3'd0,
    OP_RD_WORD  = 3'd1,
    OP_WR_BYTE  = 3'd2,
    OP_PUSH     = 3'd3,
    OP_POP      = 3'd4,
    OP_LOAD_ROM = 3'd5
  } hmmb_op_e;

  typedef enum logic [3:0] {
    RG_ROM    = 4'd0,
    RG_VRAM   = 4'd1,
    RG_XRAM   = 4'd2,
    RG_WRAM   = 4'd3,
    RG_ECHO   = 4'd4,
    RG_OAM    = 4'd5,
    RG_UNUSED = 4'd6,
    RG_IO     = 4'd7,
    RG_HRAM   = 4'd8,
    RG_IE     = 4'd9
  } hmmb_region_e;

  localparam logic [6:0] IO_SB_IDX    = 7'h01;
  localparam logic [6:0] IO_SC_IDX    = 7'h02;
  localparam logic [7:0] SERIAL_START = 8'h81;
  localparam logic [7:0] UNUSED_BYTE  = 8'hFF;

  typedef struct packed {
    logic latch_in;
    logic phase0;
    logic phase1;
    logic cap_lo;
    logic out_load;
  } hmmb_cmd_t;

  typedef struct packed {
    logic out_free;
  } hmmb_stat_t;

  function automatic hmmb_region_e hmmb_decode(input logic [15:0] a);
    hmmb_region_e r;
    priority if (a <= 16'h7FFF) r = RG_ROM;
    else if (a <= 16'h9FFF) r = RG_VRAM;
    else if (a <= 16'hBFFF) r = RG_XRAM;
    else if (a <= 16'hDFFF) r = RG_WRAM;
    else if (a <= 16'hFDFF) r = RG_ECHO;
    else if (a <= 16'hFE9F) r = RG_OAM;
    else if (a <= 16'hFEFF) r = RG_UNUSED;
    else if (a <= 16'hFF7F) r = RG_IO;
    else if (a <= 16'hFFFE) r = RG_HRAM;
    else r = RG_IE;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/handheld_memory_map_bus.sv
// Sequence: an accepted request passes through the first access, the second
// access and the result load; the load waits for a free result register.
// A new request is taken only when idle, after the previous result load; the
// result register lets it be taken while that result waits downstream.
// Reset: asynchronous, active low; clears control state and interrupt enable.
// Memories are not cleared and hold unknown contents until written.
`default_nettype none

module handheld_memory_map_bus (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], address[18:3], write_data[34:19], stack_pointer[50:35], zero fill
  input  wire  [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // read_data[15:0], new_stack_pointer[31:16], serial_byte[39:32]
  output logic [39:0] m_axis_tdata,
  // serial_valid[0]
  output logic [0:0]  m_axis_tuser
);
  import hmmb_pkg::*;

  hmmb_cmd_t  cmd;
  hmmb_stat_t stat;

  logic [15:0] read_data, new_stack_pointer;
  logic        serial_valid;
  logic [7:0]  serial_byte;

  hmmb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hmmb_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .operation_i         (s_axis_tdata[2:0]),
    .address_i           (s_axis_tdata[18:3]),
    .write_data_i        (s_axis_tdata[34:19]),
    .stack_pointer_i     (s_axis_tdata[50:35]),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .read_data_o         (read_data),
    .new_stack_pointer_o (new_stack_pointer),
    .serial_valid_o      (serial_valid),
    .serial_byte_o       (serial_byte)
  );

  assign m_axis_tdata = {serial_byte, new_stack_pointer, read_data};
  assign m_axis_tuser = serial_valid;

endmodule

`default_nettype wire

>>> src/hmmb_ctrl.sv
`default_nettype none

module hmmb_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  hmmb_pkg::hmmb_stat_t stat_i,
  output hmmb_pkg::hmmb_cmd_t  cmd_o
);
  import hmmb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIRST  = 4'b0010,
    ST_SECOND = 4'b0100,
    ST_LAST   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd_o.phase0 = 1'b1;
        state_d      = ST_SECOND;
      end
      ST_SECOND: begin
        cmd_o.phase1 = 1'b1;
        cmd_o.cap_lo = 1'b1;
        state_d      = ST_LAST;
      end
      ST_LAST: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/hmmb_dp.sv
`default_nettype none

module hmmb_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  hmmb_pkg::hmmb_cmd_t  cmd_i,
  output hmmb_pkg::hmmb_stat_t stat_o,
  input  wire  [2:0]           operation_i,
  input  wire  [15:0]          address_i,
  input  wire  [15:0]          write_data_i,
  input  wire  [15:0]          stack_pointer_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [15:0]          read_data_o,
  output logic [15:0]          new_stack_pointer_o,
  output logic                 serial_valid_o,
  output logic [7:0]           serial_byte_o
);
  import hmmb_pkg::*;

  localparam int unsigned RomDepth  = 32768;
  localparam int unsigned BankDepth = 8192;
  localparam int unsigned OamDepth  = 160;
  localparam int unsigned IoDepth   = 128;
  localparam int unsigned HramDepth = 127;

  logic [2:0]  op_q;
  logic [15:0] addr_q, wdata_q, sp_q;

  logic [7:0] rom_mem  [RomDepth];
  logic [7:0] vram_mem [BankDepth];
  logic [7:0] xram_mem [BankDepth];
  logic [7:0] wram_mem [BankDepth];
  logic [7:0] oam_mem  [OamDepth];
  logic [7:0] io_mem   [IoDepth];
  logic [7:0] hram_mem [HramDepth];

  logic [7:0] rom_rd_q, vram_rd_q, xram_rd_q, wram_rd_q, oam_rd_q, io_rd_q, hram_rd_q;
  logic [7:0] ie_q, sb_q, lo_q;
  hmmb_region_e rsel_q;

  logic        acc_re, acc_we, rom_we;
  logic [15:0] acc_addr;
  logic [7:0]  acc_wv, io_wv, rbyte;
  hmmb_region_e region;
  logic        io_fire;

  logic        ser_fire_q;
  logic [7:0]  ser_byte_q;
  logic        out_valid_q;
  logic [15:0] rd_out_q, nsp_out_q;
  logic        ser_out_q;
  logic [7:0]  ser_byte_out_q;
  logic [15:0] rd_d, nsp_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= operation_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      sp_q    <= stack_pointer_i;
    end
  end

  always_comb begin
    acc_re   = 1'b0;
    acc_we   = 1'b0;
    rom_we   = 1'b0;
    acc_addr = addr_q;
    acc_wv   = wdata_q[7:0];
    if (cmd_i.phase0) begin
      unique case (op_q)
        OP_RD_BYTE, OP_RD_WORD: acc_re = 1'b1;
        OP_WR_BYTE: acc_we = 1'b1;
        OP_PUSH: begin
          acc_we   = 1'b1;
          acc_addr = sp_q - 16'd1;
          acc_wv   = wdata_q[15:8];
        end
        OP_POP: begin
          acc_re   = 1'b1;
          acc_addr = sp_q;
        end
        OP_LOAD_ROM: rom_we = ~addr_q[15];
        default: ;
      endcase
    end else if (cmd_i.phase1) begin
      unique case (op_q)
        OP_RD_WORD: begin
          acc_re   = 1'b1;
          acc_addr = addr_q + 16'd1;
        end
        OP_PUSH: begin
          acc_we   = 1'b1;
          acc_addr = sp_q - 16'd2;
        end
        OP_POP: begin
          acc_re   = 1'b1;
          acc_addr = sp_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  assign region  = hmmb_decode(acc_addr);
  assign io_fire = acc_we && (region == RG_IO) && (acc_addr[6:0] == IO_SC_IDX)
                   && (acc_wv == SERIAL_START);
  assign io_wv   = io_fire ? 8'h00 : acc_wv;

  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[addr_q[14:0]] <= wdata_q[7:0];
    if (acc_re && region == RG_ROM) rom_rd_q <= rom_mem[acc_addr[14:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_VRAM) vram_mem[acc_addr[12:0]] <= acc_wv;
    if (acc_re && region == RG_VRAM) vram_rd_q <= vram_mem[acc_addr[12:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_XRAM) xram_mem[acc_addr[12:0]] <= acc_wv;
    if (acc_re && region == RG_XRAM) xram_rd_q <= xram_mem[acc_addr[12:0]];
  end

  // echo region maps onto the same offsets, read only
  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_WRAM) wram_mem[acc_addr[12:0]] <= acc_wv;
    if (acc_re && (region == RG_WRAM || region == RG_ECHO)) begin
      wram_rd_q <= wram_mem[acc_addr[12:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_OAM) oam_mem[acc_addr[7:0]] <= acc_wv;
    if (acc_re && region == RG_OAM) oam_rd_q <= oam_mem[acc_addr[7:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_IO) io_mem[acc_addr[6:0]] <= io_wv;
    if (acc_re && region == RG_IO) io_rd_q <= io_mem[acc_addr[6:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_HRAM) hram_mem[acc_addr[6:0]] <= acc_wv;
    if (acc_re && region == RG_HRAM) hram_rd_q <= hram_mem[acc_addr[6:0]];
  end

  // copy of serial data register for transfer start
  always_ff @(posedge clk_i) begin
    if (acc_we && region == RG_IO && acc_addr[6:0] == IO_SB_IDX) sb_q <= acc_wv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ie_q <= 8'h00;
    end else if (acc_we && region == RG_IE) begin
      ie_q <= acc_wv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_re) rsel_q <= region;
  end

  always_comb begin
    unique case (rsel_q)
      RG_ROM:            rbyte = rom_rd_q;
      RG_VRAM:           rbyte = vram_rd_q;
      RG_XRAM:           rbyte = xram_rd_q;
      RG_WRAM, RG_ECHO:  rbyte = wram_rd_q;
      RG_OAM:            rbyte = oam_rd_q;
      RG_UNUSED:         rbyte = UNUSED_BYTE;
      RG_IO:             rbyte = io_rd_q;
      RG_HRAM:           rbyte = hram_rd_q;
      RG_IE:             rbyte = ie_q;
      default:           rbyte = UNUSED_BYTE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lo) lo_q <= rbyte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_fire_q <= 1'b0;
    end else if (cmd_i.latch_in) begin
      ser_fire_q <= 1'b0;
    end else if (io_fire) begin
      ser_fire_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (io_fire) ser_byte_q <= sb_q;
  end

  always_comb begin
    rd_d  = 16'h0000;
    nsp_d = sp_q;
    unique case (op_q)
      OP_RD_BYTE: rd_d = {8'h00, lo_q};
      OP_RD_WORD: rd_d = {rbyte, lo_q};
      OP_PUSH:    nsp_d = sp_q - 16'd2;
      OP_POP: begin
        rd_d  = {rbyte, lo_q};
        nsp_d = sp_q + 16'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rd_out_q       <= rd_d;
      nsp_out_q      <= nsp_d;
      ser_out_q      <= ser_fire_q;
      ser_byte_out_q <= ser_fire_q ? ser_byte_q : 8'h00;
    end
  end

  assign stat_o.out_free     = ~out_valid_q | out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_out_q;
  assign new_stack_pointer_o = nsp_out_q;
  assign serial_valid_o      = ser_out_q;
  assign serial_byte_o       = ser_byte_out_q;

endmodule

`default_nettype wire
